/* design/assert_macros.svh */
// Assertion macros shared by the disk scan request scheduler RTL.
// Depends on nothing; users must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define DSRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define DSRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DSRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/dsrs_pkg.sv */
// Package of the disk scan request scheduler: sizes, codes, FSM state and
// the structs passed between the sequencer and the scan unit. No dependencies.
`timescale 1ns / 1ps

package dsrs_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int TRACK_BITS = 8;
  localparam int DIST_BITS  = TRACK_BITS + 1;
  localparam int IDX_BITS   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;
  localparam int STATUS_BITS = 2;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  localparam logic REG_START_TRACK = 1'b0;
  localparam logic REG_CIRCULAR    = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_ADDED   = 2'd0,
    ST_DROPPED = 2'd1,
    ST_SERVED  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_LAST,
    S_EVAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  clear;
    logic                  rd_en;
    logic [IDX_BITS-1:0]   rd_idx;
    logic [TRACK_BITS-1:0] pos;
    logic                  up;
  } scan_ctrl_t;

  typedef struct packed {
    logic                  found;
    logic [IDX_BITS-1:0]   idx;
    logic [TRACK_BITS-1:0] track;
    logic [TRACK_BITS-1:0] span;
  } scan_res_t;

endpackage

/* design/dsrs_req_if.sv */
// Request channel of the disk scan request scheduler: valid, ready, op, track.
// Depends on dsrs_pkg.
`timescale 1ns / 1ps

interface dsrs_req_if;
  import dsrs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [TRACK_BITS-1:0] track;

  modport source (output valid, output op, output track, input ready);
  modport sink (input valid, input op, input track, output ready);
endinterface

/* design/dsrs_rsp_if.sv */
// Result channel of the disk scan request scheduler: valid, ready and result fields.
// Depends on dsrs_pkg.
`timescale 1ns / 1ps

interface dsrs_rsp_if;
  import dsrs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [TRACK_BITS-1:0]  served_track;
  logic [DIST_BITS-1:0]   distance;
  logic                   wrapped;
  logic                   moving_up;

  modport source (output valid, output status, output served_track, output distance,
                  output wrapped, output moving_up, input ready);
  modport sink (input valid, input status, input served_track, input distance,
                input wrapped, input moving_up, output ready);
endinterface

/* design/dsrs_ram.sv */
// Generic RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dsrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/dsrs_scan.sv */
// Shared scan unit: one slot per cycle, one subtract and compare, keeps the
// nearest eligible slot seen in the current pass. Depends on dsrs_pkg.
`timescale 1ns / 1ps

module dsrs_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  dsrs_pkg::scan_ctrl_t          ctrl,
  input  logic [dsrs_pkg::POOL_DEPTH-1:0] slot_valid,
  input  logic [dsrs_pkg::TRACK_BITS-1:0] rdata,
  output dsrs_pkg::scan_res_t           res
);
  import dsrs_pkg::*;

  logic                  en_q;
  logic [IDX_BITS-1:0]   idx_q;
  logic                  found;
  logic [IDX_BITS-1:0]   best_idx;
  logic [TRACK_BITS-1:0] best_track;
  logic [TRACK_BITS-1:0] best_dist;
  logic                  elig;
  logic [TRACK_BITS-1:0] gap;
  logic                  take;

  always_ff @(posedge clk) begin
    if (rst) begin
      en_q <= 1'b0;
    end else begin
      en_q <= ctrl.rd_en;
    end
    idx_q <= ctrl.rd_idx;
  end

  always_comb begin
    if (ctrl.up) begin
      elig = (rdata >= ctrl.pos);
      gap  = rdata - ctrl.pos;
    end else begin
      elig = (rdata <= ctrl.pos);
      gap  = ctrl.pos - rdata;
    end
    take = en_q && slot_valid[idx_q] && elig && (!found || (gap < best_dist));
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
    if (take && !ctrl.clear) begin
      best_idx   <= idx_q;
      best_track <= rdata;
      best_dist  <= gap;
    end
  end

  assign res = '{found: found, idx: best_idx, track: best_track, span: best_dist};

endmodule

/* design/disk_scan_request_scheduler.sv */
// Top level of the disk scan request scheduler: sequencer, slot valid bits,
// head state, APB registers and result register. Uses dsrs_pkg, the channel
// interfaces, dsrs_ram and dsrs_scan.
//
//   Channel  Dir   Beat contents
//   req      in    op, track
//   rsp      out   status, served_track, distance, wrapped, moving_up
//   apb      in    start_track at 0x0, circular_mode at 0x4
//
// An add goes through S_ADD to S_DONE; a serve scans every slot (S_SCAN, S_LAST,
// S_EVAL) and scans again when the sweep turns or wraps; a serve of an empty pool
// skips to S_DONE. The single RAM read port and comparator see one slot a cycle.
// Reset clears the valid bits at once; no clearing pass is needed.
// req is ready only between items; a stalled result holds in the output
// register while the next item is already at work.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module disk_scan_request_scheduler (
  input  logic                           clk,
  input  logic                           rst,
  dsrs_req_if.sink                       req,
  dsrs_rsp_if.source                     rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dsrs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [dsrs_pkg::DATA_BITS-1:0] pwdata,
  output logic [dsrs_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);
  import dsrs_pkg::*;

  state_t                state;
  state_t                state_next;

  logic [TRACK_BITS-1:0] start_track;
  logic                  circular_mode;
  logic [POOL_DEPTH-1:0] slot_valid;
  logic [TRACK_BITS-1:0] head_track;
  logic                  head_loaded;
  logic                  direction_up;

  logic [IDX_BITS-1:0]   cnt;
  logic [TRACK_BITS-1:0] track_q;
  logic                  pass_num;
  logic                  wrap_pass;
  logic [TRACK_BITS-1:0] pass_pos;
  logic                  pass_up;

  status_t               pend_status;
  logic [TRACK_BITS-1:0] pend_served;
  logic [DIST_BITS-1:0]  pend_dist;
  logic                  pend_wrapped;
  logic                  pend_up;

  logic                  out_vld;
  status_t               out_status;
  logic [TRACK_BITS-1:0] out_served;
  logic [DIST_BITS-1:0]  out_dist;
  logic                  out_wrapped;
  logic                  out_up;

  logic                  accept;
  logic                  cfg_we;
  logic [TRACK_BITS-1:0] head_eff;
  logic                  any_valid;
  logic                  full;
  logic [IDX_BITS-1:0]   free_idx;
  logic                  in_ready;
  logic                  add_do;
  logic                  eval_do;
  logic                  out_load;
  logic                  retry;
  scan_ctrl_t            scan_ctrl;
  scan_res_t             scan_res;
  logic [TRACK_BITS-1:0] rdata;

  assign accept    = req.valid && req.ready;
  assign head_eff  = head_loaded ? head_track : start_track;
  assign any_valid = |slot_valid;
  assign full      = &slot_valid;

  always_comb begin
    free_idx = '0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = IDX_BITS'(i);
      end
    end
  end

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_track   <= '0;
      circular_mode <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_START_TRACK: start_track   <= pwdata[TRACK_BITS-1:0];
        REG_CIRCULAR:    circular_mode <= pwdata[0];
        default:         start_track   <= start_track;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_START_TRACK: prdata = DATA_BITS'(start_track);
      REG_CIRCULAR:    prdata = DATA_BITS'(circular_mode);
      default:         prdata = '0;
    endcase
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.op == OP_SERVE) begin
            state_next = any_valid ? S_SCAN : S_DONE;
          end else begin
            state_next = S_ADD;
          end
        end
      end
      S_ADD:  state_next = S_DONE;
      S_SCAN: begin
        if (cnt == IDX_BITS'(POOL_DEPTH - 1)) begin
          state_next = S_LAST;
        end
      end
      S_LAST: state_next = S_EVAL;
      S_EVAL: begin
        if (scan_res.found || pass_num) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready = 1'b0;
    add_do   = 1'b0;
    eval_do  = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_ADD:  add_do   = 1'b1;
      S_EVAL: eval_do  = 1'b1;
      S_DONE: out_load = !out_vld || rsp.ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign req.ready = in_ready;
  assign retry     = eval_do && !scan_res.found && !pass_num;

  assign scan_ctrl = '{clear: accept || retry, rd_en: (state == S_SCAN), rd_idx: cnt,
                       pos: pass_pos, up: pass_up};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == S_SCAN) begin
      cnt <= cnt + 1'b1;
    end else begin
      cnt <= '0;
    end
  end

  // Pass setup and item state.
  always_ff @(posedge clk) begin
    if (accept) begin
      track_q   <= req.track;
      pass_num  <= 1'b0;
      wrap_pass <= 1'b0;
      pass_pos  <= head_eff;
      pass_up   <= direction_up;
    end else if (retry) begin
      pass_num <= 1'b1;
      if (direction_up && circular_mode) begin
        wrap_pass <= 1'b1;
        pass_pos  <= '0;
        pass_up   <= 1'b1;
      end else begin
        wrap_pass <= 1'b0;
        pass_pos  <= head_eff;
        pass_up   <= !direction_up;
      end
    end
  end

  // Pool valid bits, head and direction.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      head_loaded  <= 1'b0;
      head_track   <= '0;
      direction_up <= 1'b1;
    end else if (add_do && !full) begin
      slot_valid[free_idx] <= 1'b1;
    end else if (eval_do && scan_res.found) begin
      slot_valid[scan_res.idx] <= 1'b0;
      head_track  <= scan_res.track;
      head_loaded <= 1'b1;
      if (pass_num && !wrap_pass) begin
        direction_up <= !direction_up;
      end
    end
  end

  // Pending result of the current item.
  always_ff @(posedge clk) begin
    if (accept && req.op == OP_SERVE && !any_valid) begin
      pend_status  <= ST_EMPTY;
      pend_served  <= '0;
      pend_dist    <= '0;
      pend_wrapped <= 1'b0;
      pend_up      <= direction_up;
    end else if (add_do) begin
      pend_status  <= full ? ST_DROPPED : ST_ADDED;
      pend_served  <= '0;
      pend_dist    <= '0;
      pend_wrapped <= 1'b0;
      pend_up      <= direction_up;
    end else if (eval_do) begin
      if (scan_res.found) begin
        pend_status  <= ST_SERVED;
        pend_served  <= scan_res.track;
        pend_wrapped <= wrap_pass;
        if (wrap_pass) begin
          pend_dist <= DIST_BITS'(head_eff) + DIST_BITS'(scan_res.track);
        end else begin
          pend_dist <= DIST_BITS'(scan_res.span);
        end
        pend_up <= (pass_num && !wrap_pass) ? !direction_up : direction_up;
      end else begin
        pend_status  <= ST_EMPTY;
        pend_served  <= '0;
        pend_dist    <= '0;
        pend_wrapped <= 1'b0;
        pend_up      <= direction_up;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
    if (out_load) begin
      out_status  <= pend_status;
      out_served  <= pend_served;
      out_dist    <= pend_dist;
      out_wrapped <= pend_wrapped;
      out_up      <= pend_up;
    end
  end

  assign rsp.valid        = out_vld;
  assign rsp.status       = out_status;
  assign rsp.served_track = out_served;
  assign rsp.distance     = out_dist;
  assign rsp.wrapped      = out_wrapped;
  assign rsp.moving_up    = out_up;

  dsrs_ram #(
    .WIDTH (TRACK_BITS),
    .DEPTH (POOL_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (add_do && !full),
    .waddr (free_idx),
    .wdata (track_q),
    .raddr (cnt),
    .rdata (rdata)
  );

  dsrs_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (scan_ctrl),
    .slot_valid (slot_valid),
    .rdata      (rdata),
    .res        (scan_res)
  );

  `DSRS_ASSERT_IMP(a_pick_valid, eval_do && scan_res.found, slot_valid[scan_res.idx], "picked slot not valid")
  `DSRS_ASSERT_NEXT(a_serve_frees, eval_do && scan_res.found, $countones(slot_valid) + 1 == $countones($past(slot_valid)), "serve did not free one slot")
  `DSRS_ASSERT_NEXT(a_add_fills, add_do && !full, $countones(slot_valid) == $countones($past(slot_valid)) + 1, "add did not fill one slot")
  `DSRS_ASSERT_IMP(a_scan_idle_req, state == S_SCAN, !req.ready && any_valid, "scan running without pending slots or while ready")

endmodule

/* bench/disk_scan_request_scheduler_tb.sv */
// Self-checking testbench for disk_scan_request_scheduler: request beats are queued,
// predicted at acceptance and compared against every result beat.
// Depends on dsrs_pkg, dsrs_req_if, dsrs_rsp_if and the scheduler RTL.
`timescale 1ns / 1ps

module disk_scan_request_scheduler_tb;
  import dsrs_pkg::*;

  typedef struct packed {
    logic                  op;
    logic [TRACK_BITS-1:0] track;
  } req_beat_t;

  typedef struct packed {
    status_t               status;
    logic [TRACK_BITS-1:0] served;
    logic [DIST_BITS-1:0]  distance;
    logic                  wrapped;
    logic                  moving_up;
  } sched_result_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  dsrs_req_if req_ch ();
  dsrs_rsp_if rsp_ch ();

  disk_scan_request_scheduler dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scheduler state as the testbench expects it.
  logic [TRACK_BITS-1:0] slot_trk [POOL_DEPTH];
  logic                  slot_busy [POOL_DEPTH] = '{default: 1'b0};
  logic [TRACK_BITS-1:0] head_trk = '0;
  logic                  head_loaded = 1'b0;
  logic                  heading_up = 1'b1;
  logic [TRACK_BITS-1:0] start_cfg = '0;
  logic                  circ_cfg = 1'b0;

  req_beat_t     pending_q [$];
  sched_result_t expected_q [$];
  int            err_count = 0;
  logic          req_taken = 1'b0;

  int       gap_left = 0;
  int       burst_left = 1;
  rx_mode_t rx_mode = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;
  int       rx_cycle = 0;
  logic     hold_trigger = 1'b0;
  logic     hold_seen = 1'b0;

  function automatic int nearest_pending(int pos, logic up);
    int best;
    int best_d;
    int d;
    int i;
    best = -1;
    best_d = 0;
    for (i = 0; i < POOL_DEPTH; i++) begin
      if (slot_busy[i]) begin
        d = -1;
        if (up && slot_trk[i] >= pos) d = slot_trk[i] - pos;
        else if (!up && slot_trk[i] <= pos) d = pos - slot_trk[i];
        if (d >= 0 && (best < 0 || d < best_d)) begin
          best = i;
          best_d = d;
        end
      end
    end
    return best;
  endfunction

  function automatic sched_result_t predict_step(logic op, logic [TRACK_BITS-1:0] trk);
    sched_result_t r;
    int head;
    int pick;
    int travel;
    int i;
    r = '0;
    pick = -1;
    travel = 0;
    if (op == OP_ADD) begin
      for (i = 0; i < POOL_DEPTH && pick < 0; i++) begin
        if (!slot_busy[i]) pick = i;
      end
      if (pick >= 0) begin
        slot_trk[pick] = trk;
        slot_busy[pick] = 1'b1;
        r.status = ST_ADDED;
      end else begin
        r.status = ST_DROPPED;
      end
    end else begin
      head = int'(head_loaded ? head_trk : start_cfg);
      if (heading_up) begin
        pick = nearest_pending(head, 1'b1);
        if (pick >= 0) begin
          travel = slot_trk[pick] - head;
        end else if (circ_cfg) begin
          pick = nearest_pending(0, 1'b1);
          if (pick >= 0) begin
            travel = head + slot_trk[pick];
            r.wrapped = 1'b1;
          end
        end else begin
          pick = nearest_pending(head, 1'b0);
          if (pick >= 0) begin
            heading_up = 1'b0;
            travel = head - slot_trk[pick];
          end
        end
      end else begin
        pick = nearest_pending(head, 1'b0);
        if (pick >= 0) begin
          travel = head - slot_trk[pick];
        end else begin
          pick = nearest_pending(head, 1'b1);
          if (pick >= 0) begin
            heading_up = 1'b1;
            travel = slot_trk[pick] - head;
          end
        end
      end
      if (pick >= 0) begin
        r.status = ST_SERVED;
        r.served = slot_trk[pick];
        r.distance = travel[DIST_BITS-1:0];
        slot_busy[pick] = 1'b0;
        head_trk = slot_trk[pick];
        head_loaded = 1'b1;
      end else begin
        r.status = ST_EMPTY;
        r.wrapped = 1'b0;
      end
    end
    r.moving_up = heading_up;
    return r;
  endfunction

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  task automatic queue_beat(input logic op, input logic [TRACK_BITS-1:0] trk);
    req_beat_t beat;
    beat.op = op;
    beat.track = trk;
    pending_q.push_back(beat);
  endtask

  task automatic reg_write(input logic idx, input logic [DATA_BITS-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BITS'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while ((pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0)
           && waited < 50000) begin
      @(negedge clk);
      waited++;
    end
    repeat (50) @(negedge clk);
  endtask

  // Acceptance of request beats and register writes updates the expected state.
  always @(posedge clk) begin
    req_taken <= !rst && req_ch.valid && req_ch.ready;
    if (!rst && psel && penable && pwrite && pready) begin
      if (paddr == ADDR_BITS'({REG_START_TRACK, 2'b00})) start_cfg = pwdata[TRACK_BITS-1:0];
      else if (paddr == ADDR_BITS'({REG_CIRCULAR, 2'b00})) circ_cfg = pwdata[0];
    end
    if (!rst && req_ch.valid && req_ch.ready)
      expected_q.push_back(predict_step(req_ch.op, req_ch.track));
  end

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_q.size() == 0) begin
        note_error($sformatf("Unexpected result beat: status=%0d track=%0d dist=%0d",
                             rsp_ch.status, rsp_ch.served_track, rsp_ch.distance));
      end else begin
        want = expected_q.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.served_track !== want.served ||
            rsp_ch.distance !== want.distance || rsp_ch.wrapped !== want.wrapped ||
            rsp_ch.moving_up !== want.moving_up)
          note_error($sformatf(
            "Mismatch: expected status=%0d track=%0d dist=%0d wrap=%0b up=%0b, %s",
            want.status, want.served, want.distance, want.wrapped, want.moving_up,
            $sformatf("got status=%0d track=%0d dist=%0d wrap=%0b up=%0b",
                      rsp_ch.status, rsp_ch.served_track, rsp_ch.distance,
                      rsp_ch.wrapped, rsp_ch.moving_up)));
      end
    end
  end

  // Request driver: bursts of beats separated by random gaps.
  always @(negedge clk) begin
    req_beat_t beat;
    if (!rst && !(req_ch.valid && !req_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        beat = pending_q.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.op <= beat.op;
        req_ch.track <= beat.track;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: a randomly drawn stall pattern (open, half, sparse, periodic),
  // with one long hold-off during random phase 2.
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = 400;
    end
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: rsp_ch.ready <= 1'b1;
        RX_HALF: rsp_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready <= rx_cycle[2];
      endcase
    end
  end

  initial begin
    int phase;
    int n;
    int add_pct;
    logic op;
    logic [TRACK_BITS-1:0] trk;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_ADD;
    req_ch.track = '0;
    rsp_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sweep mode: empty serve, equal tracks on the head, then a turn at the top.
    reg_write(REG_START_TRACK, 200);
    reg_write(REG_CIRCULAR, 0);
    queue_beat(OP_SERVE, 8'hFF);
    queue_beat(OP_ADD, 8'd0);
    queue_beat(OP_ADD, 8'd255);
    queue_beat(OP_ADD, 8'd200);
    queue_beat(OP_ADD, 8'd200);
    queue_beat(OP_ADD, 8'd210);
    repeat (6) queue_beat(OP_SERVE, TRACK_BITS'($urandom_range(0, 255)));
    drain();

    // Circular mode entered while heading down, then wraps; start_track is stale.
    reg_write(REG_START_TRACK, 5);
    reg_write(REG_CIRCULAR, 1);
    queue_beat(OP_ADD, 8'd30);
    queue_beat(OP_ADD, 8'd3);
    queue_beat(OP_SERVE, 8'd0);
    queue_beat(OP_SERVE, 8'd77);
    queue_beat(OP_ADD, 8'd7);
    queue_beat(OP_SERVE, 8'd0);
    queue_beat(OP_ADD, 8'd255);
    queue_beat(OP_SERVE, 8'd0);
    queue_beat(OP_ADD, 8'd254);
    queue_beat(OP_SERVE, 8'd0);
    drain();

    for (phase = 0; phase < 8; phase++) begin
      reg_write(REG_START_TRACK, (phase == 0) ? 255 : (phase == 1) ? 0 : $urandom_range(0, 255));
      reg_write(REG_CIRCULAR, phase % 2);
      case (phase % 4)
        0: add_pct = 85;
        1: add_pct = 50;
        2: add_pct = 60;
        default: add_pct = 25;
      endcase
      if (phase == 2) hold_trigger = !hold_trigger;
      for (n = 0; n < 200; n++) begin
        op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_SERVE;
        case ($urandom_range(0, 3))
          0: trk = $urandom_range(0, 1) ? '1 : '0;
          1: trk = TRACK_BITS'($urandom_range(120, 135));
          default: trk = TRACK_BITS'($urandom_range(0, (1 << TRACK_BITS) - 1));
        endcase
        queue_beat(op, trk);
      end
      drain();
    end

    if (expected_q.size() != 0)
      note_error($sformatf("%0d expected results never arrived", expected_q.size()));
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
